### rtl/ambrot_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ambrot_pkg
// Types and constants shared by the first-order ambisonic rotator.
// -----------------------------------------------------------------------------
package ambrot_pkg;

   localparam int unsigned SAMPLE_BITS        = 24;
   localparam int unsigned COEF_FRAC_BITS_DEF = 16;
   localparam int unsigned CSR_DATA_BITS      = 32;
   localparam int unsigned CSR_ADDR_BITS      = 5;
   localparam int unsigned NUM_REGS           = 6;
   localparam int unsigned REG_IDX_BITS       = 3;

   typedef logic [REG_IDX_BITS-1:0] reg_idx_type;

   localparam reg_idx_type REG_COS_YAW   = 3'd0;
   localparam reg_idx_type REG_SIN_YAW   = 3'd1;
   localparam reg_idx_type REG_COS_PITCH = 3'd2;
   localparam reg_idx_type REG_SIN_PITCH = 3'd3;
   localparam reg_idx_type REG_COS_ROLL  = 3'd4;
   localparam reg_idx_type REG_SIN_ROLL  = 3'd5;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   typedef struct packed {
      sample_type w_in;
      sample_type y_in;
      sample_type z_in;
      sample_type x_in;
   } req_payload_type;

   typedef struct packed {
      sample_type w_out;
      sample_type y_out;
      sample_type z_out;
      sample_type x_out;
   } rsp_payload_type;

   // channels a cell does not rotate, carried alongside
   typedef struct packed {
      sample_type p0;
      sample_type p1;
   } pass_type;

endpackage : ambrot_pkg
`default_nettype wire

### rtl/ambrot_csr.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ambrot_csr
// Coefficient register file behind the APB-style port (sines and cosines).
// -----------------------------------------------------------------------------
module ambrot_csr
   import ambrot_pkg::*;
#(
   parameter int unsigned COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0]          csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0]          csr_pwdata,
   output logic      [CSR_DATA_BITS-1:0]          csr_prdata,
   output logic                                   csr_pready,
   output logic      [NUM_REGS-1:0][COEF_FRAC_BITS+1:0] coef
);

   localparam int unsigned COEF_BITS = COEF_FRAC_BITS + 2;
   localparam logic [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << COEF_FRAC_BITS;

   logic [NUM_REGS-1:0][COEF_BITS-1:0] coef_ff;
   logic [NUM_REGS-1:0][COEF_BITS-1:0] coef_in;
   reg_idx_type                        idx;
   logic                               idx_ok;
   logic [COEF_BITS-1:0]               rd_sel;

   assign idx    = csr_paddr[REG_IDX_BITS+1:2];
   assign idx_ok = (idx <= REG_SIN_ROLL);

   always_comb begin
      coef_in = coef_ff;
      if (csr_psel && csr_penable && csr_pwrite && idx_ok) begin
         coef_in[idx] = csr_pwdata[COEF_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[REG_COS_YAW]   <= COEF_ONE;
         coef_ff[REG_SIN_YAW]   <= '0;
         coef_ff[REG_COS_PITCH] <= COEF_ONE;
         coef_ff[REG_SIN_PITCH] <= '0;
         coef_ff[REG_COS_ROLL]  <= COEF_ONE;
         coef_ff[REG_SIN_ROLL]  <= '0;
      end else begin
         coef_ff <= coef_in;
      end
   end

   always_comb begin
      rd_sel = '0;
      if (idx_ok) begin
         rd_sel = coef_ff[idx];
      end
   end

   // registers read back sign-extended
   assign csr_prdata = {{(CSR_DATA_BITS-COEF_BITS){rd_sel[COEF_BITS-1]}}, rd_sel};
   assign csr_pready = 1'b1;
   assign coef       = coef_ff;

endmodule : ambrot_csr
`default_nettype wire

### rtl/ambrot_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ambrot_cell
// One plane rotation: a' = a*c + b*s, b' = b*c - a*s, rounded and saturated.
// Stage one holds the four products, stage two the rounded results.
// -----------------------------------------------------------------------------
module ambrot_cell
   import ambrot_pkg::*;
#(
   parameter int unsigned COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              in_valid,
   output logic                                   in_ready,
   input  wire sample_type                        a_in,
   input  wire sample_type                        b_in,
   input  wire pass_type                          pass_in,
   input  wire logic signed [COEF_FRAC_BITS+1:0]  cos_in,
   input  wire logic signed [COEF_FRAC_BITS+1:0]  sin_in,
   output logic                                   out_valid,
   input  wire logic                              out_ready,
   output sample_type                             a_out,
   output sample_type                             b_out,
   output pass_type                               pass_out
);

   localparam int unsigned COEF_BITS = COEF_FRAC_BITS + 2;
   localparam int unsigned PROD_BITS = SAMPLE_BITS + COEF_BITS;
   localparam int unsigned SUM_BITS  = PROD_BITS + 1;
   localparam logic signed [SUM_BITS-1:0] ROUND_HALF =
      SUM_BITS'(1) << (COEF_FRAC_BITS - 1);
   localparam logic signed [SUM_BITS-1:0] SAT_HI =
      SUM_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [SUM_BITS-1:0] SAT_LO =
      SUM_BITS'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

   // stage one: products
   logic                         v1_ff, v1_in;
   logic signed [PROD_BITS-1:0]  ac_ff, bs_ff, bc_ff, as_ff;
   pass_type                     pass1_ff;
   // stage two: results
   logic                         v2_ff, v2_in;
   sample_type                   a2_ff, b2_ff;
   pass_type                     pass2_ff;

   logic                         ready1, ready2;
   logic signed [SUM_BITS-1:0]   sum_a, sum_b, sh_a, sh_b;
   sample_type                   a2_in, b2_in;

   assign ready2   = !v2_ff || out_ready;
   assign ready1   = !v1_ff || ready2;
   assign in_ready = ready1;
   assign v1_in    = ready1 ? in_valid : v1_ff;
   assign v2_in    = ready2 ? v1_ff : v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready1) begin
         ac_ff    <= PROD_BITS'(a_in) * PROD_BITS'(cos_in);
         bs_ff    <= PROD_BITS'(b_in) * PROD_BITS'(sin_in);
         bc_ff    <= PROD_BITS'(b_in) * PROD_BITS'(cos_in);
         as_ff    <= PROD_BITS'(a_in) * PROD_BITS'(sin_in);
         pass1_ff <= pass_in;
      end
   end

   // round half up, then clamp to the sample range
   always_comb begin
      sum_a = SUM_BITS'(ac_ff) + SUM_BITS'(bs_ff) + ROUND_HALF;
      sum_b = SUM_BITS'(bc_ff) - SUM_BITS'(as_ff) + ROUND_HALF;
      sh_a  = sum_a >>> COEF_FRAC_BITS;
      sh_b  = sum_b >>> COEF_FRAC_BITS;
      if (sh_a > SAT_HI) begin
         a2_in = SAMPLE_BITS'(SAT_HI);
      end else if (sh_a < SAT_LO) begin
         a2_in = SAMPLE_BITS'(SAT_LO);
      end else begin
         a2_in = sh_a[SAMPLE_BITS-1:0];
      end
      if (sh_b > SAT_HI) begin
         b2_in = SAMPLE_BITS'(SAT_HI);
      end else if (sh_b < SAT_LO) begin
         b2_in = SAMPLE_BITS'(SAT_LO);
      end else begin
         b2_in = sh_b[SAMPLE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ready2) begin
         a2_ff    <= a2_in;
         b2_ff    <= b2_in;
         pass2_ff <= pass1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign a_out     = a2_ff;
   assign b_out     = b2_ff;
   assign pass_out  = pass2_ff;

endmodule : ambrot_cell
`default_nettype wire

### rtl/ambisonic_rotate_first_order.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ambisonic_rotate_first_order
// First-order ambisonic rotator: yaw, pitch and roll cells in a chain.
// -----------------------------------------------------------------------------
//  channel   ports       handshake            payload
//  request   req_*       valid / stall        req_payload_type (w, y, z, x)
//  response  rsp_*       valid / stall        rsp_payload_type (w, y, z, x)
//  control   csr_*       apb-style, 32 bits   six coefficient registers
//
//  one frame a clock unless the response stalls; each rotation cell holds a
//  product register then a rounded-result register
//  synchronous reset empties the pipeline and loads unit cosines, zero sines
//  a stall on the response backs up stage by stage; the request stalls only
//  once every stage ahead of it is full
// -----------------------------------------------------------------------------
module ambisonic_rotate_first_order
   import ambrot_pkg::*;
#(
   parameter int unsigned COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire req_payload_type           req_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output rsp_payload_type                rsp_data,
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0]  csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic      [CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                           csr_pready
);

   logic [NUM_REGS-1:0][COEF_FRAC_BITS+1:0] coef;

   logic       yaw_ready, yaw_valid, pitch_ready, pitch_valid, roll_ready, roll_valid;
   sample_type y1, x1, z2, x2, z3, y3;
   pass_type   yaw_pass_in, yaw_pass, pitch_pass_in, pitch_pass, roll_pass_in, roll_pass;

   ambrot_csr #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .coef        (coef)
   );

   // yaw: y with x, w and z ride along
   assign yaw_pass_in = '{p0: req_data.w_in, p1: req_data.z_in};

   ambrot_cell #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_yaw (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (yaw_ready),
      .a_in      (req_data.y_in),
      .b_in      (req_data.x_in),
      .pass_in   (yaw_pass_in),
      .cos_in    (coef[REG_COS_YAW]),
      .sin_in    (coef[REG_SIN_YAW]),
      .out_valid (yaw_valid),
      .out_ready (pitch_ready),
      .a_out     (y1),
      .b_out     (x1),
      .pass_out  (yaw_pass)
   );

   // pitch: z with the new x
   assign pitch_pass_in = '{p0: yaw_pass.p0, p1: y1};

   ambrot_cell #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_pitch (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (yaw_valid),
      .in_ready  (pitch_ready),
      .a_in      (yaw_pass.p1),
      .b_in      (x1),
      .pass_in   (pitch_pass_in),
      .cos_in    (coef[REG_COS_PITCH]),
      .sin_in    (coef[REG_SIN_PITCH]),
      .out_valid (pitch_valid),
      .out_ready (roll_ready),
      .a_out     (z2),
      .b_out     (x2),
      .pass_out  (pitch_pass)
   );

   // roll: z first so the same cell gives z3 = z*c + y*s, y3 = y*c - z*s
   assign roll_pass_in = '{p0: pitch_pass.p0, p1: x2};

   ambrot_cell #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_roll (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pitch_valid),
      .in_ready  (roll_ready),
      .a_in      (z2),
      .b_in      (pitch_pass.p1),
      .pass_in   (roll_pass_in),
      .cos_in    (coef[REG_COS_ROLL]),
      .sin_in    (coef[REG_SIN_ROLL]),
      .out_valid (roll_valid),
      .out_ready (!rsp_stall),
      .a_out     (z3),
      .b_out     (y3),
      .pass_out  (roll_pass)
   );

   assign req_stall = !yaw_ready;
   assign rsp_valid = roll_valid;
   assign rsp_data  = '{w_out: roll_pass.p0, y_out: y3, z_out: z3, x_out: roll_pass.p1};

endmodule : ambisonic_rotate_first_order
`default_nettype wire

### rtl/ambrot_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ambrot_checker
// Port-level checks for the ambisonic rotator, bound to the top level.
// -----------------------------------------------------------------------------
module ambrot_checker
   import ambrot_pkg::*;
(
   input wire logic            clock,
   input wire logic            reset,
   input wire logic            req_valid,
   input wire logic            req_stall,
   input wire req_payload_type req_data,
   input wire logic            rsp_valid,
   input wire logic            rsp_stall,
   input wire rsp_payload_type rsp_data
);

   // pipeline comes out of reset empty
   a_empty_after_reset : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a free-running response side never backs up into the request
   a_no_stall_when_drained : assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("request stalled while response is not stalled");

   // held response transaction keeps its data
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // with no stall and no reset, w leaves unchanged once it has passed every pipeline register
   a_w_latency : assert property (@(posedge clock) disable iff (reset)
      ($past(req_valid && !req_stall && !reset, 6) &&
       !$past(rsp_stall, 1) && !$past(rsp_stall, 2) && !$past(rsp_stall, 3) &&
       !$past(rsp_stall, 4) && !$past(rsp_stall, 5) &&
       !$past(reset, 1) && !$past(reset, 2) && !$past(reset, 3) &&
       !$past(reset, 4) && !$past(reset, 5))
      |-> rsp_valid && (rsp_data.w_out == $past(req_data.w_in, 6)))
      else $error("w pass-through lost or late");

endmodule : ambrot_checker

bind ambisonic_rotate_first_order ambrot_checker u_ambrot_checker (.*);
`default_nettype wire

### tb/sv/ambisonic_rotate_first_order_tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ambisonic_rotate_first_order_tb
// Self-checking bench for the first-order ambisonic rotator. Frames are pushed
// through the request channel under random idling and a long response
// hold-off. Each accepted frame is rotated by a local yaw, pitch and roll
// predictor, using shadow copies of the coefficient registers. Every response
// transaction is checked field by field against the oldest predicted frame.
// -----------------------------------------------------------------------------
module ambisonic_rotate_first_order_tb;
   import ambrot_pkg::*;

   localparam int unsigned COEF_BITS = COEF_FRAC_BITS_DEF + 2;
   localparam reg_idx_type REG_SPARE_6 = 3'd6;
   localparam reg_idx_type REG_SPARE_7 = 3'd7;
   localparam int DRAIN_CYCLES    = 12;
   localparam int DRAIN_LIMIT     = 5000;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam longint SAMPLE_MAX  = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
   localparam longint SAMPLE_MIN  = -(longint'(1) <<< (SAMPLE_BITS - 1));

   typedef logic signed [COEF_BITS-1:0] coef_type;

   localparam coef_type COEF_ONE    = coef_type'(18'h10000);
   localparam coef_type COEF_NEG    = coef_type'(18'h30000);
   localparam coef_type COEF_HALF   = coef_type'(18'h08000);
   localparam coef_type COEF_ZERO   = coef_type'(18'h00000);
   localparam coef_type COEF_TOP    = coef_type'(18'h1FFFF);
   localparam coef_type COEF_BOTTOM = coef_type'(18'h20000);
   localparam sample_type SAMPLE_TOP    = sample_type'(24'h7FFFFF);
   localparam sample_type SAMPLE_BOTTOM = sample_type'(24'h800000);

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_valid   = 1'b0;
   logic                     req_stall;
   req_payload_type          req_data    = '0;
   logic                     rsp_valid;
   logic                     rsp_stall   = 1'b0;
   rsp_payload_type          rsp_data;
   logic                     csr_psel    = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr   = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   coef_type        coef_shadow [NUM_REGS];
   rsp_payload_type rotated_q [$];
   int              fail_count      = 0;
   int              req_idle_pct    = 12;
   int              rsp_idle_pct    = 55;
   int              rsp_hold_cycles = 0;

   ambisonic_rotate_first_order u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // round half towards plus infinity, then clamp to the sample range
   function automatic sample_type round_to_sample(longint acc);
      longint q;
      q = (acc + (longint'(1) <<< (COEF_FRAC_BITS_DEF - 1))) >>> COEF_FRAC_BITS_DEF;
      if (q > SAMPLE_MAX) q = SAMPLE_MAX;
      if (q < SAMPLE_MIN) q = SAMPLE_MIN;
      return sample_type'(q);
   endfunction

   function automatic rsp_payload_type rotate_frame(req_payload_type f);
      longint cy, sy, cp, sp, cr, sr;
      longint y1, x1, z2, x2, y3, z3;
      rsp_payload_type r;
      cy = coef_shadow[REG_COS_YAW];
      sy = coef_shadow[REG_SIN_YAW];
      cp = coef_shadow[REG_COS_PITCH];
      sp = coef_shadow[REG_SIN_PITCH];
      cr = coef_shadow[REG_COS_ROLL];
      sr = coef_shadow[REG_SIN_ROLL];
      y1 = round_to_sample(longint'(f.y_in) * cy + longint'(f.x_in) * sy);
      x1 = round_to_sample(longint'(f.x_in) * cy - longint'(f.y_in) * sy);
      z2 = round_to_sample(longint'(f.z_in) * cp + x1 * sp);
      x2 = round_to_sample(x1 * cp - longint'(f.z_in) * sp);
      y3 = round_to_sample(y1 * cr - z2 * sr);
      z3 = round_to_sample(y1 * sr + z2 * cr);
      r.w_out = f.w_in;
      r.y_out = sample_type'(y3);
      r.z_out = sample_type'(z3);
      r.x_out = sample_type'(x2);
      return r;
   endfunction

   function automatic sample_type rand_sample();
      case ($urandom_range(9))
         0: return SAMPLE_TOP;
         1: return SAMPLE_BOTTOM;
         2: return sample_type'(int'($urandom_range(64)) - 32);
         default: return sample_type'($urandom);
      endcase
   endfunction

   // mostly values in the unit range, now and then any 18-bit pattern
   function automatic coef_type rand_coef();
      if ($urandom_range(4) == 0) return coef_type'($urandom);
      return coef_type'(int'($urandom_range(131072)) - 65536);
   endfunction

   task automatic check_field(string name, sample_type want, sample_type got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   // response checker
   always @(posedge clock) begin : rsp_check
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rotated_q.size() == 0) begin
            $error("response transaction with no frame outstanding");
            fail_count++;
         end else begin
            want = rotated_q.pop_front();
            check_field("w_out", want.w_out, rsp_data.w_out);
            check_field("y_out", want.y_out, rsp_data.y_out);
            check_field("z_out", want.z_out, rsp_data.z_out);
            check_field("x_out", want.x_out, rsp_data.x_out);
         end
      end
   end

   // response side: a requested hold-off first, random stalls otherwise
   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_stall = 1'b1;
         rsp_hold_cycles--;
      end else begin
         rsp_stall = ($urandom_range(99) < rsp_idle_pct);
      end
   end

   // called at a falling edge, returns at one; valid stays high for a follow-on
   task automatic send_frame(req_payload_type f);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = f;
      do @(posedge clock); while (req_stall);
      rotated_q.push_back(rotate_frame(f));
      @(negedge clock);
   endtask

   task automatic send_rand_frames(int n);
      repeat (n)
         send_frame(req_payload_type'{rand_sample(), rand_sample(), rand_sample(),
                                      rand_sample()});
   endtask

   task automatic drain_pipeline();
      int waited;
      req_valid = 1'b0;
      waited = 0;
      while (rotated_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      if (rotated_q.size() != 0) begin
         $error("%0d expected response transactions never arrived", rotated_q.size());
         fail_count++;
         rotated_q.delete();
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // write, then read back where the index names a real register
   task automatic csr_write(reg_idx_type idx, coef_type val);
      logic [CSR_DATA_BITS-1:0] rd;
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = CSR_DATA_BITS'(val);
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      if (idx < NUM_REGS) begin
         coef_shadow[idx] = val;
         csr_psel = 1'b1;
         @(negedge clock);
         csr_penable = 1'b1;
         do @(posedge clock); while (!csr_pready);
         rd = csr_prdata;
         @(negedge clock);
         csr_psel    = 1'b0;
         csr_penable = 1'b0;
         if (rd[COEF_BITS-1:0] !== val) begin
            $error("register %0d readback mismatch: expected %0d, actual %0d",
                   idx, val, coef_type'(rd[COEF_BITS-1:0]));
            fail_count++;
         end
      end
   endtask

   task automatic load_coefs(coef_type cy, coef_type sy, coef_type cp, coef_type sp,
                             coef_type cr, coef_type sr);
      drain_pipeline();
      csr_write(REG_COS_YAW, cy);
      csr_write(REG_SIN_YAW, sy);
      csr_write(REG_COS_PITCH, cp);
      csr_write(REG_SIN_PITCH, sp);
      csr_write(REG_COS_ROLL, cr);
      csr_write(REG_SIN_ROLL, sr);
   endtask

   // identity rotation straight out of reset
   task automatic test_reset_defaults();
      send_frame(req_payload_type'{'0, '0, '0, '0});
      send_frame(req_payload_type'{SAMPLE_TOP, SAMPLE_TOP, SAMPLE_TOP, SAMPLE_TOP});
      send_frame(req_payload_type'{SAMPLE_BOTTOM, SAMPLE_BOTTOM, SAMPLE_BOTTOM,
                                   SAMPLE_BOTTOM});
      send_frame(req_payload_type'{SAMPLE_TOP, SAMPLE_BOTTOM, sample_type'(-1),
                                   sample_type'(1)});
   endtask

   task automatic test_register_access();
      load_coefs(coef_type'(12345), coef_type'(-23456), coef_type'(54321),
                 coef_type'(-1), COEF_TOP, COEF_BOTTOM);
      // unmapped indices must leave the coefficients alone
      csr_write(REG_SPARE_6, coef_type'($urandom));
      csr_write(REG_SPARE_7, coef_type'($urandom));
      send_rand_frames(2);
   endtask

   // coefficients beyond unity drive every stage into both rails
   task automatic test_saturation();
      load_coefs(COEF_TOP, COEF_TOP, COEF_TOP, COEF_TOP, COEF_TOP, COEF_TOP);
      send_frame(req_payload_type'{SAMPLE_TOP, SAMPLE_TOP, SAMPLE_TOP, SAMPLE_TOP});
      send_frame(req_payload_type'{SAMPLE_BOTTOM, SAMPLE_BOTTOM, SAMPLE_BOTTOM,
                                   SAMPLE_BOTTOM});
      send_frame(req_payload_type'{'0, SAMPLE_TOP, SAMPLE_BOTTOM, SAMPLE_TOP});
      load_coefs(COEF_BOTTOM, COEF_BOTTOM, COEF_BOTTOM, COEF_BOTTOM, COEF_BOTTOM,
                 COEF_BOTTOM);
      send_frame(req_payload_type'{SAMPLE_TOP, SAMPLE_TOP, SAMPLE_TOP, SAMPLE_TOP});
      send_frame(req_payload_type'{SAMPLE_BOTTOM, SAMPLE_BOTTOM, SAMPLE_BOTTOM,
                                   SAMPLE_BOTTOM});
   endtask

   // a gain of one half lands odd samples exactly on a rounding tie
   task automatic test_half_rounding();
      load_coefs(COEF_HALF, COEF_ZERO, COEF_HALF, COEF_ZERO, COEF_HALF, COEF_ZERO);
      send_frame(req_payload_type'{'0, sample_type'(1), sample_type'(1), sample_type'(1)});
      send_frame(req_payload_type'{'0, sample_type'(-1), sample_type'(-1),
                                   sample_type'(-1)});
      send_frame(req_payload_type'{SAMPLE_TOP, sample_type'(3), sample_type'(-3),
                                   sample_type'(5)});
   endtask

   // quarter turns and a half turn negate the most negative sample
   task automatic test_quarter_turns();
      load_coefs(COEF_ZERO, COEF_ONE, COEF_ZERO, COEF_ONE, COEF_ZERO, COEF_ONE);
      send_frame(req_payload_type'{SAMPLE_BOTTOM, SAMPLE_BOTTOM, SAMPLE_BOTTOM,
                                   SAMPLE_BOTTOM});
      send_frame(req_payload_type'{SAMPLE_TOP, SAMPLE_TOP, SAMPLE_BOTTOM, SAMPLE_TOP});
      load_coefs(COEF_NEG, COEF_ZERO, COEF_NEG, COEF_ZERO, COEF_NEG, COEF_ZERO);
      send_frame(req_payload_type'{SAMPLE_BOTTOM, SAMPLE_BOTTOM, SAMPLE_BOTTOM,
                                   SAMPLE_BOTTOM});
   endtask

   // long response hold-off so the pipeline fills and stalls the request side
   task automatic test_backpressure();
      load_coefs(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                 rand_coef());
      req_idle_pct    = 0;
      rsp_hold_cycles = HOLD_OFF_CYCLES;
      send_rand_frames(40);
   endtask

   task automatic test_random_traffic();
      int mode;
      for (mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               req_idle_pct = 12;
               rsp_idle_pct = 55;
            end
            1: begin
               req_idle_pct = 55;
               rsp_idle_pct = 12;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         repeat (4) begin
            load_coefs(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                       rand_coef());
            send_rand_frames(108);
         end
      end
   endtask

   initial begin
      coef_shadow[REG_COS_YAW]   = COEF_ONE;
      coef_shadow[REG_SIN_YAW]   = COEF_ZERO;
      coef_shadow[REG_COS_PITCH] = COEF_ONE;
      coef_shadow[REG_SIN_PITCH] = COEF_ZERO;
      coef_shadow[REG_COS_ROLL]  = COEF_ONE;
      coef_shadow[REG_SIN_ROLL]  = COEF_ZERO;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_defaults();
      test_register_access();
      test_saturation();
      test_half_rounding();
      test_quarter_turns();
      test_backpressure();
      test_random_traffic();
      drain_pipeline();
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

### sim.f
rtl/ambrot_pkg.sv
rtl/ambrot_csr.sv
rtl/ambrot_cell.sv
rtl/ambisonic_rotate_first_order.sv
rtl/ambrot_checker.sv
tb/sv/ambisonic_rotate_first_order_tb.sv
